### design/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg
// Opcodes, error codes and transfer payload types of the checked integer ALU.
// ----------------------------------------------------------------------------
package cia_pkg;

   localparam int DATA_BITS = 64;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_DIV = 4'd3,
      OP_MOD = 4'd4,
      OP_SHL = 4'd5,
      OP_SHR = 4'd6,
      OP_AND = 4'd7,
      OP_OR  = 4'd8,
      OP_XOR = 4'd9,
      OP_ROL = 4'd10,
      OP_ROR = 4'd11
   } op_type;

   typedef enum logic [1:0] {
      ERR_OK   = 2'd0,
      ERR_OVF  = 2'd1,
      ERR_DIV0 = 2'd2
   } err_type;

   typedef struct packed {
      logic [3:0]                  op;
      logic signed [DATA_BITS-1:0] operand_a;
      logic signed [DATA_BITS-1:0] operand_b;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_BITS-1:0] result;
      logic [1:0]                  error;
   } rsp_payload_type;

endpackage

### design/cia_mul.sv
// ----------------------------------------------------------------------------
// cia_mul
// Two-stage unsigned multiplier: half-word partial products, then their sum.
// ----------------------------------------------------------------------------
module cia_mul #(
   parameter int WIDTH = 64
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [WIDTH-1:0]     mult_a,
   input  logic [WIDTH-1:0]     mult_b,
   output logic [2*WIDTH-1:0]   product
);

   localparam int LO = WIDTH / 2;
   localparam int HI = WIDTH - LO;

   logic [2*LO-1:0]    pp_ll_ff, pp_ll_in;
   logic [LO+HI-1:0]   pp_lh_ff, pp_lh_in;
   logic [LO+HI-1:0]   pp_hl_ff, pp_hl_in;
   logic [2*HI-1:0]    pp_hh_ff, pp_hh_in;
   logic [2*WIDTH-1:0] prod_ff, prod_in;

   always_comb begin
      pp_ll_in = mult_a[LO-1:0] * mult_b[LO-1:0];
      pp_lh_in = (LO+HI)'(mult_a[LO-1:0]) * (LO+HI)'(mult_b[WIDTH-1:LO]);
      pp_hl_in = (LO+HI)'(mult_a[WIDTH-1:LO]) * (LO+HI)'(mult_b[LO-1:0]);
      pp_hh_in = mult_a[WIDTH-1:LO] * mult_b[WIDTH-1:LO];
      prod_in  = (2*WIDTH)'(pp_ll_ff)
               + ((2*WIDTH)'(pp_lh_ff) << LO)
               + ((2*WIDTH)'(pp_hl_ff) << LO)
               + ((2*WIDTH)'(pp_hh_ff) << (2*LO));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ll_ff <= pp_ll_in;
         pp_lh_ff <= pp_lh_in;
         pp_hl_ff <= pp_hl_in;
         pp_hh_ff <= pp_hh_in;
         prod_ff  <= prod_in;
      end
   end

   assign product = prod_ff;

endmodule

### design/cia_divider.sv
// ----------------------------------------------------------------------------
// cia_divider
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module cia_divider #(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   logic [WIDTH-1:0] rem_ff [WIDTH];
   logic [WIDTH-1:0] rem_in [WIDTH];
   logic [WIDTH-1:0] quo_ff [WIDTH];
   logic [WIDTH-1:0] quo_in [WIDTH];
   logic [WIDTH-1:0] dsr_ff [WIDTH];
   logic [WIDTH-1:0] dsr_in [WIDTH];
   logic [WIDTH-1:0] prev_rem [WIDTH];
   logic [WIDTH-1:0] prev_quo [WIDTH];
   logic [WIDTH:0]   shifted [WIDTH];
   logic [WIDTH:0]   diff [WIDTH];

   always_comb begin
      for (int i = 0; i < WIDTH; i++) begin
         if (i == 0) begin
            prev_rem[i] = '0;
            prev_quo[i] = dividend;
            dsr_in[i]   = divisor;
         end else begin
            prev_rem[i] = rem_ff[i-1];
            prev_quo[i] = quo_ff[i-1];
            dsr_in[i]   = dsr_ff[i-1];
         end
         shifted[i] = {prev_rem[i], prev_quo[i][WIDTH-1]};
         diff[i]    = shifted[i] - {1'b0, dsr_in[i]};
         if (!diff[i][WIDTH]) begin
            rem_in[i] = diff[i][WIDTH-1:0];
            quo_in[i] = {prev_quo[i][WIDTH-2:0], 1'b1};
         end else begin
            rem_in[i] = shifted[i][WIDTH-1:0];
            quo_in[i] = {prev_quo[i][WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < WIDTH; i++) begin
            rem_ff[i] <= rem_in[i];
            quo_ff[i] <= quo_in[i];
            dsr_ff[i] <= dsr_in[i];
         end
      end
   end

   assign quotient  = quo_ff[WIDTH-1];
   assign remainder = rem_ff[WIDTH-1];

endmodule

### design/checked_integer_alu_unit.sv
// ----------------------------------------------------------------------------
// checked_integer_alu_unit
// Pipelined signed ALU with overflow and divide-by-zero reporting.
//
//   channel  direction  ports                              payload
//   req      in         req_valid, req_stall, req_payload  op, operand_a, operand_b
//   rsp      out        rsp_valid, rsp_stall, rsp_payload  result, error
//
// one transfer per cycle while req_stall is low; the pipeline depth is set by the
// divider, which resolves one quotient bit per stage
// all ops share the same pipeline so results leave in request order
// reset clears the stage valid bits and the valid bits of the output register and the skid stage
// a stalled output parks one result in the skid stage; req_stall rises
// only while that stage is full, and then the whole pipeline holds
// ----------------------------------------------------------------------------
module checked_integer_alu_unit
   import cia_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam int KW    = $clog2(WIDTH);
   localparam int SUMW  = $clog2(64 * WIDTH);
   localparam int PW    = SUMW + 17;
   localparam int RECIP = 65536 / WIDTH;
   localparam int LAST  = WIDTH;

   typedef struct packed {
      op_type           op;
      logic             a_neg;
      logic             b_neg;
      logic [WIDTH-1:0] res;
      err_type          err;
      logic [SUMW-1:0]  rsum;
      logic [SUMW-1:0]  rq;
      logic [KW-1:0]    rk;
   } side_type;

   function automatic int pow2_mod(input int n);
      int r;
      r = 1;
      for (int j = 0; j < n; j++) begin
         r = 2 * r;
         if (r >= WIDTH) begin
            r = r - WIDTH;
         end
      end
      return r;
   endfunction

   side_type         side_ff [LAST+1];
   side_type         side_in [LAST+1];
   side_type         dec_side;
   logic             valid_ff [LAST+1];
   logic             valid_in [LAST+1];
   logic [WIDTH-1:0] amag_ff, amag_in;
   logic [WIDTH-1:0] bmag_ff, bmag_in;

   logic             en;
   logic [WIDTH-1:0] op_a, op_b, sum_ab, dif_ab;
   logic [63:0]      cnt;
   logic [KW-1:0]    sh;
   logic             big;

   logic [2*WIDTH-1:0] product;
   logic [2*WIDTH-1:0] mul_lim;
   logic               mul_neg;
   logic [SUMW:0]      kt;
   logic [KW-1:0]      rot_k;
   logic [2*WIDTH-1:0] rot_tmp;
   logic [PW-1:0]      q_prod;

   logic [WIDTH-1:0]        quotient, remainder;
   logic signed [WIDTH-1:0] fin_res;
   rsp_payload_type         last_data;

   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type skid_ff, skid_in;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // decode and the ops resolved at decode
   always_comb begin
      op_a   = req_payload.operand_a[WIDTH-1:0];
      op_b   = req_payload.operand_b[WIDTH-1:0];
      cnt    = req_payload.operand_b;
      sum_ab = op_a + op_b;
      dif_ab = op_a - op_b;
      big    = cnt >= 64'(WIDTH);
      sh     = cnt[KW-1:0];

      dec_side.op    = op_type'(req_payload.op);
      dec_side.a_neg = op_a[WIDTH-1];
      dec_side.b_neg = op_b[WIDTH-1];
      dec_side.err   = ERR_OK;
      dec_side.res   = '0;
      dec_side.rq    = '0;
      dec_side.rk    = '0;
      dec_side.rsum  = '0;
      for (int i = 0; i < 64; i++) begin
         if (cnt[i]) begin
            dec_side.rsum = dec_side.rsum + SUMW'(pow2_mod(i));
         end
      end
      amag_in = op_a[WIDTH-1] ? -op_a : op_a;
      bmag_in = op_b[WIDTH-1] ? -op_b : op_b;

      case (dec_side.op)
         OP_ADD: begin
            dec_side.res = sum_ab;
            if (((op_a ^ sum_ab) & (op_b ^ sum_ab)) >> (WIDTH - 1) != '0) begin
               dec_side.err = ERR_OVF;
            end
         end
         OP_SUB: begin
            dec_side.res = dif_ab;
            if (((op_a ^ op_b) & (op_a ^ dif_ab)) >> (WIDTH - 1) != '0) begin
               dec_side.err = ERR_OVF;
            end
         end
         OP_MUL: dec_side.res = '0;
         OP_DIV: begin
            if (op_b == '0) begin
               dec_side.err = ERR_DIV0;
            end else if (op_a == {1'b1, {(WIDTH-1){1'b0}}} && op_b == '1) begin
               dec_side.err = ERR_OVF;
            end
         end
         OP_MOD: begin
            if (op_b == '0) begin
               dec_side.err = ERR_DIV0;
            end
         end
         OP_SHL: dec_side.res = big ? '0 : (op_a << sh);
         OP_SHR: dec_side.res = big ? '0 : (op_a >> sh);
         OP_AND: dec_side.res = op_a & op_b;
         OP_OR:  dec_side.res = op_a | op_b;
         OP_XOR: dec_side.res = op_a ^ op_b;
         OP_ROL: dec_side.res = op_a;
         OP_ROR: dec_side.res = op_a;
         default: dec_side.res = '0;
      endcase
   end

   // later stages: rotate count reduction, multiply check, rotate
   always_comb begin
      mul_neg = side_ff[2].a_neg ^ side_ff[2].b_neg;
      mul_lim = mul_neg ? ((2*WIDTH)'(1) << (WIDTH - 1))
                        : (((2*WIDTH)'(1) << (WIDTH - 1)) - (2*WIDTH)'(1));
      q_prod  = PW'(side_ff[0].rsum) * PW'(RECIP);
      kt      = (SUMW+1)'(side_ff[1].rsum) - (SUMW+1)'(side_ff[1].rq * SUMW'(WIDTH));
      if (side_ff[2].op == OP_ROR && side_ff[2].rk != '0) begin
         rot_k = KW'(WIDTH) - side_ff[2].rk;
      end else begin
         rot_k = side_ff[2].rk;
      end
      rot_tmp = {side_ff[2].res, side_ff[2].res} << rot_k;

      side_in[0]  = dec_side;
      valid_in[0] = req_valid && en;
      for (int i = 1; i <= LAST; i++) begin
         side_in[i]  = side_ff[i-1];
         valid_in[i] = valid_ff[i-1];
      end

      side_in[1].rq = SUMW'(q_prod >> 16);
      side_in[2].rk = (kt >= (SUMW+1)'(WIDTH)) ? KW'(kt - (SUMW+1)'(WIDTH)) : KW'(kt);

      case (side_ff[2].op)
         OP_MUL: begin
            if (product > mul_lim) begin
               side_in[3].err = ERR_OVF;
               side_in[3].res = '0;
            end else begin
               side_in[3].res = mul_neg ? -product[WIDTH-1:0] : product[WIDTH-1:0];
            end
         end
         OP_ROL, OP_ROR: side_in[3].res = rot_tmp[2*WIDTH-1:WIDTH];
         default: side_in[3].res = side_ff[2].res;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         amag_ff <= amag_in;
         bmag_ff <= bmag_in;
         for (int i = 0; i <= LAST; i++) begin
            side_ff[i] <= side_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         for (int i = 0; i <= LAST; i++) begin
            valid_ff[i] <= valid_in[i];
         end
      end
   end

   cia_mul #(.WIDTH(WIDTH)) u_mul (
      .clock   (clock),
      .en      (en),
      .mult_a  (amag_ff),
      .mult_b  (bmag_ff),
      .product (product)
   );

   cia_divider #(.WIDTH(WIDTH)) u_div (
      .clock     (clock),
      .en        (en),
      .dividend  (amag_ff),
      .divisor   (bmag_ff),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // sign fixup for divide and remainder, error zeroing
   always_comb begin
      case (side_ff[LAST].op)
         OP_DIV: fin_res = (side_ff[LAST].a_neg ^ side_ff[LAST].b_neg) ? -quotient : quotient;
         OP_MOD: fin_res = side_ff[LAST].a_neg ? -remainder : remainder;
         default: fin_res = side_ff[LAST].res;
      endcase
      if (side_ff[LAST].err != ERR_OK) begin
         fin_res = '0;
      end
      last_data.result = 64'(fin_res);
      last_data.error  = side_ff[LAST].err;
   end

   // output register and skid stage
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = last_data;
            out_valid_in = valid_ff[LAST];
         end
      end else if (en && valid_ff[LAST]) begin
         skid_in       = last_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage full while output register empty");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.error != ERR_OK |-> out_ff.result == '0)
      else $error("nonzero result with error flagged");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.error != 2'd3)
      else $error("undefined error code");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      !skid_valid_ff && skid_valid_in |-> out_valid_ff && rsp_stall)
      else $error("skid stage filled without an output stall");

endmodule

### test/tb_checked_integer_alu_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_checked_integer_alu_unit
// Drives opcode and operand transfers into the checked integer ALU, predicts
// each result and error code, and compares them in order with the response
// channel under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_checked_integer_alu_unit;
   import cia_pkg::*;

   localparam int W = 64;
   localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ALL_ONES = '1;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;

   rsp_payload_type expected_rsps[$];
   int  error_count;
   int  src_idle_pct;
   int  sink_idle_pct;

   checked_integer_alu_unit #(.WIDTH(W)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic logic [63:0] magnitude(logic [63:0] v);
      return v[63] ? 64'd0 - v : v;
   endfunction

   function automatic rsp_payload_type alu_predict(req_payload_type p);
      rsp_payload_type o;
      logic [63:0]  a, b, r, q, lim;
      logic [127:0] prod;
      logic         neg;
      int           k;
      a = p.operand_a;
      b = p.operand_b;
      r = '0;
      o.error = ERR_OK;
      case (p.op)
         OP_ADD: begin
            r = a + b;
            if (((a ^ r) & (b ^ r) & SIGN_BIT) != 0) o.error = ERR_OVF;
         end
         OP_SUB: begin
            r = a - b;
            if (((a ^ b) & (a ^ r) & SIGN_BIT) != 0) o.error = ERR_OVF;
         end
         OP_MUL: begin
            neg = a[63] ^ b[63];
            lim = neg ? SIGN_BIT : SIGN_BIT - 64'd1;
            prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
            if (prod[127:64] != 0 || prod[63:0] > lim) o.error = ERR_OVF;
            else r = neg ? 64'd0 - prod[63:0] : prod[63:0];
         end
         OP_DIV: begin
            if (b == 0) o.error = ERR_DIV0;
            else if (a == SIGN_BIT && b == ALL_ONES) o.error = ERR_OVF;
            else begin
               q = magnitude(a) / magnitude(b);
               r = (a[63] ^ b[63]) ? 64'd0 - q : q;
            end
         end
         OP_MOD: begin
            if (b == 0) o.error = ERR_DIV0;
            else begin
               q = magnitude(a) % magnitude(b);
               r = a[63] ? 64'd0 - q : q;
            end
         end
         OP_SHL: r = (b >= W) ? 64'd0 : a << b[5:0];
         OP_SHR: r = (b >= W) ? 64'd0 : a >> b[5:0];
         OP_AND: r = a & b;
         OP_OR:  r = a | b;
         OP_XOR: r = a ^ b;
         OP_ROL, OP_ROR: begin
            k = b[5:0];
            if (p.op == OP_ROR && k != 0) k = W - k;
            r = (k == 0) ? a : (a << k) | (a >> (W - k));
         end
         default: r = '0;
      endcase
      if (o.error != ERR_OK) r = '0;
      o.result = r;
      return o;
   endfunction

   task automatic send_item(logic [3:0] op, logic [63:0] a, logic [63:0] b);
      req_payload_type p;
      p.op = op;
      p.operand_a = a;
      p.operand_b = b;
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      expected_rsps.push_back(alu_predict(p));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // keep valid high across back-to-back transfers by only lowering in gaps
   task automatic send_burst_end();
      req_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < sink_idle_pct);
   end

   always @(posedge clock) begin
      rsp_payload_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected transfer: result %h error %0d",
                   rsp_payload.result, rsp_payload.error);
            error_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_payload.result !== e.result) begin
               $error("result: expected %h actual %h", e.result, rsp_payload.result);
               error_count++;
            end
            if (rsp_payload.error !== e.error) begin
               $error("error: expected %0d actual %0d", e.error, rsp_payload.error);
               error_count++;
            end
         end
      end
   end

   function automatic logic [63:0] rand_operand();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(7))
         0: v = SIGN_BIT;
         1: v = ~SIGN_BIT;
         2: v = ALL_ONES;
         3: v = $urandom_range(0, 3);
         4: v = {{32{v[31]}}, v[31:0]};
         5: v = {{48{v[15]}}, v[15:0]};
         default: ;
      endcase
      return v;
   endfunction

   task automatic test_directed();
      send_item(OP_ADD, ~SIGN_BIT, 64'd1);
      send_item(OP_ADD, SIGN_BIT, ALL_ONES);
      send_item(OP_ADD, 64'd5, ALL_ONES);
      send_item(OP_SUB, SIGN_BIT, 64'd1);
      send_item(OP_SUB, 64'd0, SIGN_BIT);
      send_item(OP_SUB, ALL_ONES, SIGN_BIT);
      send_item(OP_MUL, SIGN_BIT, 64'd1);
      send_item(OP_MUL, SIGN_BIT, ALL_ONES);
      send_item(OP_MUL, 64'h0000_0001_0000_0000, 64'h0000_0000_8000_0000);
      send_item(OP_MUL, 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_8000_0000);
      send_item(OP_DIV, 64'd7, 64'd0);
      send_item(OP_DIV, SIGN_BIT, ALL_ONES);
      send_item(OP_DIV, -64'sd7, 64'd2);
      send_item(OP_MOD, -64'sd7, 64'd2);
      send_item(OP_MOD, SIGN_BIT, ALL_ONES);
      send_item(OP_MOD, 64'd3, 64'd0);
      send_item(OP_SHL, ALL_ONES, 64'd63);
      send_item(OP_SHL, ALL_ONES, 64'd64);
      send_item(OP_SHR, ALL_ONES, SIGN_BIT);
      send_item(OP_AND, ALL_ONES, 64'hA5A5_5A5A_0F0F_F0F0);
      send_item(OP_OR, 64'd0, SIGN_BIT);
      send_item(OP_XOR, ALL_ONES, 64'h1234_5678_9ABC_DEF0);
      send_item(OP_ROL, SIGN_BIT | 64'd1, 64'd65);
      send_item(OP_ROR, 64'd1, ALL_ONES);
      send_item(4'd15, ALL_ONES, ALL_ONES);
   endtask

   task automatic test_random(int count);
      logic [3:0]  op;
      logic [63:0] b;
      repeat (count) begin
         op = ($urandom_range(19) == 0) ? 4'($urandom_range(12, 15))
                                         : 4'($urandom_range(0, 11));
         b = rand_operand();
         if (op >= OP_SHL && op != OP_AND && op != OP_OR && op != OP_XOR
             && $urandom_range(3) != 0)
            b = $urandom_range(0, 130);
         send_item(op, rand_operand(), b);
      end
   endtask

   initial begin
      int wait_cycles;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      rsp_stall    = 1'b0;
      error_count  = 0;
      src_idle_pct = 15;
      sink_idle_pct = 87;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(325);
      src_idle_pct  = 87;
      sink_idle_pct = 15;
      test_random(350);
      src_idle_pct  = 0;
      sink_idle_pct = 0;
      test_random(350);
      send_burst_end();
      wait_cycles = 0;
      while (expected_rsps.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (W + 10) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
